// File: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: request and
// result transactions, request and status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

  // list geometry
  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);

  // fixed field widths of the transactions
  localparam int REQ_W   = 3;
  localparam int VAL_W   = 8;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_DUMP      = 3'd6
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SLOT_FRONT = 2'd0,
    SLOT_BACK  = 2'd1,
    SLOT_POS   = 2'd2
  } slot_sel_t;

  // request transaction
  typedef struct packed {
    req_code_t        req_type;
    logic [VAL_W-1:0] element_value;
    logic [POS_W-1:0] position;
  } req_t;

  // result transaction
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] element_count;
    logic [VAL_W-1:0]   dump_value;
    logic               dump_valid;
    logic               last_result;
  } res_t;

  // controller to datapath
  typedef struct packed {
    op_t       op;
    slot_sel_t slot;
    logic      load_res;
    status_t   status;
    logic      take_dump;
    logic      last;
    logic      dump_start;
    logic      dump_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic dump_last;
    logic res_free;
  } stat_t;

endpackage

// File: rtl/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// Element store as a row of shift cells, fill count, dump read index and the
// result register. Executes the commands issued by the controller.
// ----------------------------------------------------------------------------
module ple_datapath (
  input  logic           clk,
  input  logic           rst,
  input  ple_pkg::req_t  req_data,
  input  ple_pkg::cmd_t  cmd,
  output ple_pkg::stat_t stat,
  input  logic           res_ready,
  output logic           res_valid,
  output ple_pkg::res_t  res_data
);

  localparam int CMP_W =
    ((ple_pkg::POS_W > ple_pkg::CNT_W) ? ple_pkg::POS_W : ple_pkg::CNT_W) + 1;

  logic [ple_pkg::DATA_WIDTH-1:0] store [ple_pkg::DEPTH];
  logic [ple_pkg::CNT_W-1:0]      count;
  logic [ple_pkg::CNT_W-1:0]      count_next;
  logic [ple_pkg::IDX_W-1:0]      dump_idx;
  logic                           res_valid_next;

  logic [ple_pkg::IDX_W-1:0]      slot;
  logic [ple_pkg::POS_W-1:0]      pos_m1;
  logic [CMP_W-1:0]               pos_c;
  logic [CMP_W-1:0]               cnt_c;
  logic [ple_pkg::DATA_WIDTH-1:0] new_val;
  logic [ple_pkg::DATA_WIDTH-1:0] dump_data;

  // position checks against the current count
  assign pos_c   = CMP_W'(req_data.position);
  assign cnt_c   = CMP_W'(count);
  assign pos_m1  = req_data.position - ple_pkg::POS_W'(1);
  assign new_val = ple_pkg::DATA_WIDTH'(req_data.element_value);

  always_comb begin
    stat.empty      = (count == '0);
    stat.full       = (count == ple_pkg::CNT_W'(ple_pkg::DEPTH));
    stat.ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
    stat.del_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
    stat.dump_last  = ((ple_pkg::CNT_W'(dump_idx) + ple_pkg::CNT_W'(1)) == count);
    stat.res_free   = !res_valid || res_ready;
  end

  // target slot of the insert or delete
  always_comb begin
    case (cmd.slot)
      ple_pkg::SLOT_FRONT: slot = '0;
      ple_pkg::SLOT_BACK: begin
        if (cmd.op == ple_pkg::OP_INSERT) begin
          slot = ple_pkg::IDX_W'(count);
        end else begin
          slot = ple_pkg::IDX_W'(count - ple_pkg::CNT_W'(1));
        end
      end
      default: slot = pos_m1[ple_pkg::IDX_W-1:0];
    endcase
  end

  // count after the request
  always_comb begin
    case (cmd.op)
      ple_pkg::OP_INSERT: count_next = count + ple_pkg::CNT_W'(1);
      ple_pkg::OP_DELETE: count_next = count - ple_pkg::CNT_W'(1);
      default:            count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // shift cells: insert opens a gap at the slot, delete closes it
  for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
    localparam logic [ple_pkg::IDX_W-1:0] CELL = ple_pkg::IDX_W'(g);
    always_ff @(posedge clk) begin
      if (cmd.op == ple_pkg::OP_INSERT) begin
        if (CELL == slot) begin
          store[g] <= new_val;
        end else if (CELL > slot) begin
          if (g > 0) begin
            store[g] <= store[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd.op == ple_pkg::OP_DELETE) begin
        if (CELL >= slot) begin
          if (g < ple_pkg::DEPTH - 1) begin
            store[g] <= store[(g < ple_pkg::DEPTH - 1) ? g + 1 : g];
          end
        end
      end
    end
  end

  // dump read index
  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      dump_idx <= '0;
    end else if (cmd.dump_step) begin
      dump_idx <= dump_idx + ple_pkg::IDX_W'(1);
    end
  end

  assign dump_data = store[dump_idx];

  // result register
  always_comb begin
    if (cmd.load_res) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      res_data.status        <= cmd.status;
      res_data.element_count <= ple_pkg::COUNT_W'(count_next);
      res_data.dump_value    <= cmd.take_dump ? ple_pkg::VAL_W'(dump_data) : '0;
      res_data.dump_valid    <= cmd.take_dump;
      res_data.last_result   <= cmd.last;
    end
  end

  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
    else $error("element count beyond depth");

  // a request moves the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) ||
             (count == $past(count) + ple_pkg::CNT_W'(1)) ||
             (count == $past(count) - ple_pkg::CNT_W'(1)))
    else $error("element count jumped");

  // dump reads only held elements
  a_dump_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_step |-> (ple_pkg::CNT_W'(dump_idx) < count))
    else $error("dump index past the list end");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !cmd.load_res)
    else $error("pending result overwritten");

endmodule

// File: rtl/ple_controller.sv
// ----------------------------------------------------------------------------
// ple_controller
// Request decoder and dump sequencer. Checks each request against the list
// status and issues insert, delete, dump and result-load commands.
// ----------------------------------------------------------------------------
module ple_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  ple_pkg::req_code_t req_code,
  input  ple_pkg::stat_t     stat,
  output logic               req_ready,
  output ple_pkg::cmd_t      cmd
);

  ple_pkg::state_t state;
  ple_pkg::state_t state_next;
  logic            take;

  assign take = req_valid && req_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::S_IDLE: begin
        if (take && req_code == ple_pkg::REQ_DUMP && !stat.empty) begin
          state_next = ple_pkg::S_DUMP;
        end
      end
      ple_pkg::S_DUMP: begin
        if (stat.res_free && stat.dump_last) begin
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    req_ready      = 1'b0;
    cmd.op         = ple_pkg::OP_NONE;
    cmd.slot       = ple_pkg::SLOT_FRONT;
    cmd.load_res   = 1'b0;
    cmd.status     = ple_pkg::ST_OK;
    cmd.take_dump  = 1'b0;
    cmd.last       = 1'b1;
    cmd.dump_start = 1'b0;
    cmd.dump_step  = 1'b0;
    case (state)
      ple_pkg::S_IDLE: begin
        req_ready = stat.res_free;
        if (take) begin
          cmd.load_res = 1'b1;
          case (req_code)
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_AT: begin
              if (req_code == ple_pkg::REQ_INS_AT && !stat.ins_pos_ok) begin
                cmd.status = ple_pkg::ST_BADPOS;
              end else if (stat.full) begin
                cmd.status = ple_pkg::ST_FULL;
              end else begin
                cmd.op = ple_pkg::OP_INSERT;
                if (req_code == ple_pkg::REQ_INS_FRONT) begin
                  cmd.slot = ple_pkg::SLOT_FRONT;
                end else if (req_code == ple_pkg::REQ_INS_BACK) begin
                  cmd.slot = ple_pkg::SLOT_BACK;
                end else begin
                  cmd.slot = ple_pkg::SLOT_POS;
                end
              end
            end
            ple_pkg::REQ_DEL_FRONT: begin
              if (!stat.empty) begin
                cmd.op   = ple_pkg::OP_DELETE;
                cmd.slot = ple_pkg::SLOT_FRONT;
              end
            end
            ple_pkg::REQ_DEL_BACK: begin
              if (!stat.empty) begin
                cmd.op   = ple_pkg::OP_DELETE;
                cmd.slot = ple_pkg::SLOT_BACK;
              end
            end
            ple_pkg::REQ_DEL_AT: begin
              if (!stat.del_pos_ok) begin
                cmd.status = ple_pkg::ST_BADPOS;
              end else begin
                cmd.op   = ple_pkg::OP_DELETE;
                cmd.slot = ple_pkg::SLOT_POS;
              end
            end
            ple_pkg::REQ_DUMP: begin
              // empty list answers at once, otherwise walk the elements
              if (!stat.empty) begin
                cmd.load_res   = 1'b0;
                cmd.dump_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ple_pkg::S_DUMP: begin
        if (stat.res_free) begin
          cmd.load_res  = 1'b1;
          cmd.take_dump = 1'b1;
          cmd.last      = stat.dump_last;
          cmd.dump_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // no new transaction while a dump is running
  a_busy_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ple_pkg::S_DUMP) |-> !req_ready)
    else $error("request taken during dump");

  // a non-empty dump enters the walk on the next cycle
  a_dump_entry: assert property (@(posedge clk) disable iff (rst)
    (take && req_code == ple_pkg::REQ_DUMP && !stat.empty) |=>
      (state == ple_pkg::S_DUMP))
    else $error("dump walk not started");

  // list contents only change on an accepted request
  a_op_on_take: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != ple_pkg::OP_NONE) |-> take)
    else $error("list changed without a request");

endmodule

// File: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH elements with insert and delete at the front,
// the back or a 1-based position, and an in-order dump.
// ----------------------------------------------------------------------------
// Insert and delete transactions each give one result: the element store is
// a row of shift cells that opens or closes a gap at the target slot, so
// such requests can be accepted on every cycle while the result register is
// free or being drained. A dump reads the store through one read index, one
// element per cycle while the result register is free, and holds off new
// requests until its last element has been loaded (no hold-off for an empty
// list, which answers at once). Each result carries the status and the
// element count after the request; the last result of a request has
// last_result set.
module positional_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ple_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output ple_pkg::res_t res_data
);

  ple_pkg::cmd_t  cmd;
  ple_pkg::stat_t stat;

  // request decode and dump sequencing
  ple_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_code  (req_data.req_type),
    .stat      (stat),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  // element store, count and result register
  ple_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

endmodule

// File: verif/list_result_checker.sv
// ----------------------------------------------------------------------------
// list_result_checker
// Watches the request and result channels of the positional list engine,
// keeps its own mirror of the held list, works out the results that each
// accepted request should give and compares every accepted result with the
// oldest one still owed. Failures, results owed and the list size go back to
// the testbench top.
// ----------------------------------------------------------------------------
module list_result_checker
  import ple_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res_data,
  output int   fail_count,
  output int   results_owed,
  output int   held_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_WIDTH-1:0] list_mirror[$];
  res_t                  expected_results[$];
  int                    failures = 0;

  // one result owed, counted after the request has taken effect
  function automatic void queue_result(input status_t st, input logic [VAL_W-1:0] v,
                                       input logic vld, input logic last);
    res_t r;
    r.status        = st;
    r.element_count = COUNT_W'(list_mirror.size());
    r.dump_value    = v;
    r.dump_valid    = vld;
    r.last_result   = last;
    expected_results.push_back(r);
  endfunction

  // apply one request to the mirror and queue what it should give
  task automatic predict_request(input req_t r);
    int unsigned           pos;
    int unsigned           fill;
    logic [DATA_WIDTH-1:0] v;
    pos  = r.position;
    fill = list_mirror.size();
    v    = r.element_value[DATA_WIDTH-1:0];
    case (r.req_type)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        // a bad position wins over a full list
        if (r.req_type == REQ_INS_AT && (pos < 1 || pos > fill + 1)) begin
          queue_result(ST_BADPOS, '0, 1'b0, 1'b1);
        end else if (fill >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          if (r.req_type == REQ_INS_FRONT) list_mirror.push_front(v);
          else if (r.req_type == REQ_INS_BACK) list_mirror.push_back(v);
          else list_mirror.insert(pos - 1, v);
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      REQ_DEL_FRONT: begin
        if (fill > 0) void'(list_mirror.pop_front());
        queue_result(ST_OK, '0, 1'b0, 1'b1);
      end
      REQ_DEL_BACK: begin
        if (fill > 0) void'(list_mirror.pop_back());
        queue_result(ST_OK, '0, 1'b0, 1'b1);
      end
      REQ_DEL_AT: begin
        if (pos < 1 || pos > fill) begin
          queue_result(ST_BADPOS, '0, 1'b0, 1'b1);
        end else begin
          list_mirror.delete(pos - 1);
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      REQ_DUMP: begin
        // an empty list still gives one closing result
        if (fill == 0) begin
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          foreach (list_mirror[i])
            queue_result(ST_OK, VAL_W'(list_mirror[i]), 1'b1, i == fill - 1);
        end
      end
      default: begin
        // spare request code leaves the list alone
        queue_result(ST_OK, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  function automatic string describe(input res_t r);
    return $sformatf("status=%0d count=%0d value=0x%02h valid=%b last=%b",
                     r.status, r.element_count, r.dump_value, r.dump_valid,
                     r.last_result);
  endfunction

  // sample both channels at the edge, requests first
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      list_mirror.delete();
      expected_results.delete();
    end else begin
      if (req_valid && req_ready) predict_request(req_data);
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("[%0t] result with nothing owed: %s", $realtime, describe(res_data));
        end else begin
          want = expected_results.pop_front();
          if (res_data.status !== want.status ||
              res_data.element_count !== want.element_count ||
              res_data.dump_value !== want.dump_value ||
              res_data.dump_valid !== want.dump_valid ||
              res_data.last_result !== want.last_result) begin
            failures++;
            if (failures <= 10)
              $display("[%0t] result mismatch\n  expected %s\n  actual   %s",
                       $realtime, describe(want), describe(res_data));
          end
        end
      end
    end
    fail_count   <= failures;
    results_owed <= expected_results.size();
    held_count   <= list_mirror.size();
  end

endmodule

// File: verif/tb_positional_list_engine.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Drives request transactions into the positional list engine: a directed
// run over empty-list, bad-position and spare-code cases, then random phases
// that grow the list to full, churn it and drain it to empty. Both channels
// idle at random and the result side holds off once for a long stretch. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPACED} rx_mode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_data;

  int   fail_count;
  int   results_owed;
  int   held_count;
  int   burst_left = 0;
  bit   gaps_on    = 1'b1;
  logic hold_off   = 1'b0;

  positional_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  list_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_data     (req_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_data     (res_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .held_count   (held_count)
  );

  always #4 clk = ~clk;

  function automatic req_t make_req(input logic [REQ_W-1:0] code,
                                    input logic [VAL_W-1:0] v,
                                    input logic [POS_W-1:0] p);
    req_t r;
    r.req_type      = req_code_t'(code);
    r.element_value = v;
    r.position      = p;
    return r;
  endfunction

  // random request, weighted by phase, positions mostly near the live range
  function automatic req_t random_req(input mix_t mix);
    int               roll;
    int               ins_pct;
    int               del_pct;
    int               top_pos;
    logic [REQ_W-1:0] code;
    logic [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    case (mix)
      MIX_GROW:   begin ins_pct = 70; del_pct = 20; end
      MIX_SHRINK: begin ins_pct = 20; del_pct = 70; end
      default:    begin ins_pct = 45; del_pct = 45; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       code = REQ_INS_FRONT;
        1:       code = REQ_INS_BACK;
        default: code = REQ_INS_AT;
      endcase
    end else if (roll < ins_pct + del_pct) begin
      case ($urandom_range(0, 2))
        0:       code = REQ_DEL_FRONT;
        1:       code = REQ_DEL_BACK;
        default: code = REQ_DEL_AT;
      endcase
    end else if (roll < 97) begin
      code = REQ_DUMP;
    end else begin
      code = REQ_SPARE;
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) v = '0;
    else if (roll < 20) v = '1;
    else v = VAL_W'($urandom_range(0, 255));
    top_pos = (held_count > 0) ? held_count : 1;
    roll = $urandom_range(0, 99);
    if (roll < 8) p = '0;
    else if (roll < 18) p = POS_W'(held_count + 1);
    else if (roll < 28) p = POS_W'($urandom_range(0, 63));
    else p = POS_W'($urandom_range(1, top_pos));
    return make_req(code, v, p);
  endfunction

  // offer one transaction, opening a gap between bursts
  task automatic offer(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gaps_on && $urandom_range(0, 9) > 2) ? $urandom_range(1, 10) : 0;
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic run_phase(input mix_t mix, input int items);
    for (int n = 0; n < items; n++) offer(random_req(mix));
  endtask

  // result side: stretches of open, random and spaced stalls, one long hold
  initial begin : receiver
    rx_mode_t mode;
    int       stretch;
    int       spacing;
    bit       hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        hold_done = 1'b1;
        res_ready <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk);
      end
      mode    = rx_mode_t'($urandom_range(0, 2));
      stretch = $urandom_range(20, 80);
      spacing = $urandom_range(2, 6);
      for (int n = 0; n < stretch; n++) begin
        case (mode)
          RX_OPEN:   res_ready <= 1'b1;
          RX_RANDOM: res_ready <= 1'($urandom_range(0, 1));
          default:   res_ready <= (n % spacing == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: dump, deletes, bad insert positions
    offer(make_req(REQ_DUMP,      8'h00, 6'd0));
    offer(make_req(REQ_DEL_FRONT, 8'h00, 6'd0));
    offer(make_req(REQ_DEL_BACK,  8'h00, 6'd0));
    offer(make_req(REQ_DEL_AT,    8'h00, 6'd1));
    offer(make_req(REQ_INS_AT,    8'h11, 6'd0));
    offer(make_req(REQ_INS_AT,    8'h22, 6'd2));
    // build a short list through every insert form
    offer(make_req(REQ_INS_AT,    8'hFF, 6'd1));
    offer(make_req(REQ_INS_FRONT, 8'h00, 6'd0));
    offer(make_req(REQ_INS_BACK,  8'hA5, 6'd63));
    offer(make_req(REQ_INS_AT,    8'h77, 6'd63));
    offer(make_req(REQ_INS_AT,    8'h5A, 6'd4));
    offer(make_req(REQ_INS_AT,    8'h3C, 6'd2));
    offer(make_req(REQ_SPARE,     8'hFF, 6'd63));
    offer(make_req(REQ_DUMP,      8'hFF, 6'd63));
    // delete forms and bad delete positions
    offer(make_req(REQ_DEL_AT,    8'h00, 6'd0));
    offer(make_req(REQ_DEL_AT,    8'h00, 6'd6));
    offer(make_req(REQ_DEL_AT,    8'h00, 6'd5));
    offer(make_req(REQ_DEL_AT,    8'h00, 6'd2));
    offer(make_req(REQ_DEL_AT,    8'h00, 6'd63));
    offer(make_req(REQ_DEL_BACK,  8'h00, 6'd0));
    offer(make_req(REQ_DEL_FRONT, 8'h00, 6'd0));
    offer(make_req(REQ_DUMP,      8'h00, 6'd0));
    offer(make_req(REQ_DEL_FRONT, 8'h00, 6'd0));
    offer(make_req(REQ_DUMP,      8'h00, 6'd0));

    // random phases: fill to full, churn, drain to empty
    run_phase(MIX_GROW, 90);
    hold_off <= 1'b1;
    gaps_on = 1'b0;
    run_phase(MIX_EVEN, 80);
    gaps_on = 1'b1;
    run_phase(MIX_SHRINK, 90);
    run_phase(MIX_GROW, 80);
    run_phase(MIX_EVEN, 50);
    run_phase(MIX_SHRINK, 60);

    // drain, then allow for a full dump still in flight
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_positional_list_engine passed");
    end else begin
      $display("tb_positional_list_engine failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_positional_list_engine failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ple_pkg.sv
rtl/ple_datapath.sv
rtl/ple_controller.sv
rtl/positional_list_engine.sv
verif/list_result_checker.sv
verif/tb_positional_list_engine.sv
